// ----- rtl/core/ppp_pkg.sv -----
// shared types, constants and helpers for the perspective point projector
package ppp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VP_W          = 14;
    localparam logic [VP_W-1:0] VP_WIDTH_RST  = 14'd1920;
    localparam logic [VP_W-1:0] VP_HEIGHT_RST = 14'd1080;

    // configuration register indexes
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } t_out_item;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/core/ppp_clip.sv -----
// matrix store and clip x, y, w dot products (two stages)
module ppp_clip #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  ppp_pkg::t_in_item         i_item,
    output logic                      o_valid,
    output logic signed [63:0]        o_cx,
    output logic signed [63:0]        o_cy,
    output logic signed [63:0]        o_cw
);
    import ppp_pkg::*;

    logic signed [31:0] r_mat [16];
    logic               r_v1;
    logic signed [63:0] r_p [9];
    logic signed [31:0] r_t [3];
    logic               r_v2;
    logic signed [63:0] r_cx, r_cy, r_cw;
    logic signed [31:0] w_pos [3];
    logic [1:0]         w_row [3];

    assign w_pos[0] = i_item.pos_x;
    assign w_pos[1] = i_item.pos_y;
    assign w_pos[2] = i_item.pos_z;
    assign w_row[0] = 2'd0;
    assign w_row[1] = 2'd1;
    assign w_row[2] = 2'd3;

    // matrix writes, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) r_mat[k] <= '0;
        end else if (i_en && i_valid && i_item.operation == OP_WRITE) begin
            r_mat[i_item.element_index] <= i_item.element_value;
        end
    end

    // stage 1: nine products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid && i_item.operation == OP_PROJECT;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[r*3+c] <= 64'(w_pos[c]) * 64'(r_mat[{w_row[r], 2'(c)}]);
                end
                r_t[r] <= r_mat[{w_row[r], 2'd3}];
            end
        end
    end

    // stage 2: floor shift and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx <= (r_p[0] >>> FRAC_BITS) + (r_p[1] >>> FRAC_BITS)
                  + (r_p[2] >>> FRAC_BITS) + 64'(r_t[0]);
            r_cy <= (r_p[3] >>> FRAC_BITS) + (r_p[4] >>> FRAC_BITS)
                  + (r_p[5] >>> FRAC_BITS) + 64'(r_t[1]);
            r_cw <= (r_p[6] >>> FRAC_BITS) + (r_p[7] >>> FRAC_BITS)
                  + (r_p[8] >>> FRAC_BITS) + 64'(r_t[2]);
        end
    end

    assign o_valid = r_v2;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_cw    = r_cw;
endmodule

// ----- rtl/core/ppp_div.sv -----
// pipelined restoring divider: saturated fixed point x/w and y/w
module ppp_div #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [63:0] i_cx,
    input  logic signed [63:0] i_cy,
    input  logic signed [63:0] i_cw,
    output logic               o_valid,
    output logic               o_visible,
    output logic signed [31:0] o_nx,
    output logic signed [31:0] o_ny
);
    import ppp_pkg::*;

    // quotient is 31 bits; one bit per stage
    localparam int QB = 31;
    localparam int NB = QB;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    // per-lane state: remainder, quotient, sign, saturate
    typedef struct packed {
        logic        neg;
        logic        sat;
        logic [64:0] rem;
        logic [QB-1:0] q;
    } t_lane;

    logic          r_v   [NB+1];
    logic          r_vis [NB+1];
    logic [63:0]   r_d   [NB+1];
    logic [63:0]   r_mx  [NB+1];
    logic [63:0]   r_my  [NB+1];
    t_lane         r_lx  [NB+1];
    t_lane         r_ly  [NB+1];
    logic signed [31:0] r_nx, r_ny;
    logic          r_vo, r_viso;

    // stage 0: visibility, magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vis[0]    <= (i_cw * 64'sd10) >= $signed(ONE);
            r_d[0]      <= i_cw;
            r_mx[0]     <= i_cx[63] ? 64'(-i_cx) : i_cx;
            r_my[0]     <= i_cy[63] ? 64'(-i_cy) : i_cy;
            r_lx[0].neg <= i_cx[63];
            r_ly[0].neg <= i_cy[63];
            r_lx[0].sat <= 1'b0;
            r_ly[0].sat <= 1'b0;
            r_lx[0].rem <= '0;
            r_ly[0].rem <= '0;
            r_lx[0].q   <= '0;
            r_ly[0].q   <= '0;
        end
    end

    // one quotient bit per stage; dividend is mag << FRAC_BITS, and its bits from
    // bit QB up form the seed remainder, which must be below d, else saturate
    function automatic t_lane step(input t_lane l, input logic [63:0] m,
                                   input logic [63:0] d, input int s);
        t_lane o;
        logic [64:0] t;
        int          b;
        o = l;
        b = s - FRAC_BITS;
        t = {l.rem[63:0], (b >= 0) ? m[b] : 1'b0};
        if (t >= {1'b0, d}) begin
            o.rem = t - {1'b0, d};
            o.q   = {l.q[QB-2:0], 1'b1};
        end else begin
            o.rem = t;
            o.q   = {l.q[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    // dividend bits above the quotient window: top part m >> (QB-FRAC_BITS)
    // must be below d (else quotient overflows); remainder starts as that top part
    function automatic t_lane seed(input t_lane l, input logic [63:0] m,
                                   input logic [63:0] d);
        t_lane       o;
        logic [63:0] top;
        o     = l;
        top   = m >> (QB - FRAC_BITS);
        o.rem = {1'b0, top};
        o.sat = top >= d;
        o.q   = '0;
        return o;
    endfunction

    for (genvar g = 0; g < NB; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vis[g+1] <= r_vis[g];
                r_d[g+1]   <= r_d[g];
                r_mx[g+1]  <= r_mx[g];
                r_my[g+1]  <= r_my[g];
                if (g == 0) begin
                    // high dividend bits first: any quotient overflow sets sat
                    r_lx[g+1] <= step(seed(r_lx[g], r_mx[g], r_d[g]),
                                      r_mx[g], r_d[g], QB-1-g);
                    r_ly[g+1] <= step(seed(r_ly[g], r_my[g], r_d[g]),
                                      r_my[g], r_d[g], QB-1-g);
                end else begin
                    r_lx[g+1] <= step(r_lx[g], r_mx[g], r_d[g], QB-1-g);
                    r_ly[g+1] <= step(r_ly[g], r_my[g], r_d[g], QB-1-g);
                end
            end
        end
    end

    // output: sign and saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[NB];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_viso <= r_vis[NB];
            r_nx <= r_lx[NB].sat ? (r_lx[NB].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                  : (r_lx[NB].neg ? -$signed({1'b0, r_lx[NB].q}) : $signed({1'b0, r_lx[NB].q}));
            r_ny <= r_ly[NB].sat ? (r_ly[NB].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                  : (r_ly[NB].neg ? -$signed({1'b0, r_ly[NB].q}) : $signed({1'b0, r_ly[NB].q}));
        end
    end

    assign o_valid   = r_vo;
    assign o_visible = r_viso;
    assign o_nx      = r_nx;
    assign o_ny      = r_ny;
endmodule

// ----- rtl/core/perspective_point_projector.sv -----
// perspective point projector top level: pipeline, viewport map, output register
// stages in order from request accept to result valid: clip, divide, viewport multiply,
// offset and output register; throughput one request per cycle while the pipeline advances:
// the pipeline advances whenever the output register is empty or being taken
// write requests update the matrix in the accept cycle and give no result
// synchronous active-low reset clears the matrix and valid bits and loads
// the viewport to 1920 by 1080
module perspective_point_projector #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ppp_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ppp_pkg::t_out_item   o_data,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [13:0]          i_cfg_data
);
    import ppp_pkg::*;

    logic               w_en;
    logic               w_cv, w_dv, w_vis;
    logic signed [63:0] w_cx, w_cy, w_cw;
    logic signed [31:0] w_nx, w_ny;
    logic [VP_W-1:0]    r_vw, r_vh;
    logic               r_mv, r_mvis;
    logic signed [63:0] r_px, r_py;
    logic signed [63:0] r_hw, r_hh;
    logic               r_ov;
    t_out_item          r_od;

    // advance when the output slot frees up
    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;

    // viewport registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw <= VP_WIDTH_RST;
            r_vh <= VP_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_vw <= i_cfg_data;
                REG_HEIGHT: r_vh <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    ppp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid),
        .i_item(i_data), .o_valid(w_cv), .o_cx(w_cx), .o_cy(w_cy), .o_cw(w_cw)
    );

    ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_cv),
        .i_cx(w_cx), .i_cy(w_cy), .i_cw(w_cw), .o_valid(w_dv),
        .o_visible(w_vis), .o_nx(w_nx), .o_ny(w_ny)
    );

    // viewport multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_en) begin
            r_mv <= w_dv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mvis <= w_vis;
            r_hw   <= 64'({1'b0, r_vw[VP_W-1:1]}) <<< FRAC_BITS;
            r_hh   <= 64'({1'b0, r_vh[VP_W-1:1]}) <<< FRAC_BITS;
            r_px   <= 64'($signed({1'b0, r_vw[VP_W-1:1]})) * 64'(w_nx);
            r_py   <= 64'($signed({1'b0, r_vh[VP_W-1:1]})) * 64'(w_ny);
        end
    end

    // offset, saturate, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_mv;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_od.visible  <= r_mvis;
            r_od.screen_x <= r_mvis ? sat32(r_px + r_hw) : '0;
            r_od.screen_y <= r_mvis ? sat32(r_hh - r_py) : '0;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;
endmodule
